// ===== hdl/rpn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared sizes, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int EXT_WIDTH   = 32;
  localparam int DEPTH_OUT_W = 5;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_POP  = 3'd6,
    OP_BAD  = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MISSING = 3'd1,
    ST_FULL    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_INVALID = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RES_ADD = 3'd0,
    RES_SUB = 3'd1,
    RES_MUL = 3'd2,
    RES_QUO = 3'd3,
    RES_REM = 3'd4
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;    // latch the token and read the two top entries
    logic     mul_load;   // register the product of the two operands
    logic     div_start;  // launch the divider
    logic     push;       // write the operand at the pointer, pointer up
    logic     wr_result;  // write the result over the second entry, pointer down
    res_sel_e res_sel;
    logic     pop;        // pointer down, hand out the top entry
    logic     out_load;   // load the result register
    status_e  out_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e opcode;
    logic    empty;
    logic    below_two;
    logic    full;
    logic    top_zero;
    logic    div_done;
  } dp_stat_t;

  // Bring a 32-bit token value to the stack width, sign-extending or truncating.
  function automatic data_t from_ext(logic [EXT_WIDTH-1:0] v);
    return DATA_WIDTH'($signed(v));
  endfunction

  // Bring a stack entry back to 32 bits, sign-extending or truncating.
  function automatic logic [EXT_WIDTH-1:0] to_ext(data_t d);
    return EXT_WIDTH'($signed(d));
  endfunction

endpackage : rpn_pkg
`default_nettype wire

// ===== hdl/rpn_stack_evaluator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN stack evaluator core
// Reverse-Polish integer evaluator with a bounded operand stack: push,
// add, subtract, multiply, divide, remainder and pop-result tokens.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   input     in_valid_i/in_stall_o  opcode_i, operand_i
//   output    out_valid_o/out_stall_i status_o, value_valid_o, popped_value_o,
//                                    stack_depth_o
//
// A token passes the execute and finish states before the next transfer;
// divide and remainder also wait on the one-bit-per-cycle divider.
// Tokens are handled one at a time, but a new token is taken while the
// previous result still waits in the output register.
// Reset clears the stack pointer and the handshake state; stack contents are
// not cleared, as only entries below the pointer ever reach a result.
// A stall on the output holds the result; the controller waits for a free
// output register before it commits the next token's stack update.
//
module rpn_stack_evaluator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    opcode_i,
  input  wire logic signed [rpn_pkg::EXT_WIDTH-1:0] operand_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic                               value_valid_o,
  output logic signed [rpn_pkg::EXT_WIDTH-1:0] popped_value_o,
  output logic [rpn_pkg::DEPTH_OUT_W-1:0]    stack_depth_o
);
  import rpn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences each token; the datapath owns all storage.
  rpn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rpn_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .operand_i      (operand_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (status_o),
    .value_valid_o  (value_valid_o),
    .popped_value_o (popped_value_o),
    .stack_depth_o  (stack_depth_o)
  );

  // A popped value is only ever reported with a good status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_valid_o |-> status_o == ST_OK)
    else $error("popped value reported with an error status");

  // Without a popped value the value field reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !value_valid_o |-> popped_value_o == '0)
    else $error("popped value not zero without a pop");

  // Tokens are handled one at a time: a transfer in closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // The reported depth never passes the stack size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(stack_depth_o) <= STACK_DEPTH)
    else $error("stack depth beyond stack size");

endmodule : rpn_stack_evaluator_core
`default_nettype wire

// ===== hdl/rpn_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN signed divider
// Restoring divider, one quotient bit per cycle, on magnitudes with the signs
// put back at the end. Quotient truncates toward zero.
// ----------------------------------------------------------------------------
module rpn_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rpn_pkg::data_t dividend_i,
  input  wire rpn_pkg::data_t divisor_i,
  output logic               done_o,
  output rpn_pkg::data_t     quotient_o,
  output rpn_pkg::data_t     remainder_o
);
  import rpn_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } div_state_e;

  div_state_e         state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;
  data_t              num_q, den_q, rem_q, quo_q, remout_q;
  logic               neg_quo_q, neg_rem_q;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  take;
  data_t                 rem_d;

  assign shifted = {rem_q, num_q[DATA_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign take    = ~diff[DATA_WIDTH+1];
  assign rem_d   = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            cnt_q   <= CNT_W'(DATA_WIDTH);
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= D_FIX;
          end
        end
        D_FIX: begin
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      num_q     <= dividend_i[DATA_WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
      den_q     <= divisor_i[DATA_WIDTH-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_q     <= '0;
      neg_quo_q <= dividend_i[DATA_WIDTH-1] ^ divisor_i[DATA_WIDTH-1];
      neg_rem_q <= dividend_i[DATA_WIDTH-1];
    end else if (state_q == D_RUN) begin
      rem_q <= rem_d;
      num_q <= {num_q[DATA_WIDTH-2:0], take};
    end else if (state_q == D_FIX) begin
      quo_q    <= neg_quo_q ? (~num_q + 1'b1) : num_q;
      remout_q <= neg_rem_q ? (~rem_q + 1'b1) : rem_q;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = remout_q;

endmodule : rpn_div
`default_nettype wire

// ===== hdl/rpn_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN datapath
// Operand stack memory, stack pointer, token latch, adder, multiplier,
// divider and the result register.
// ----------------------------------------------------------------------------
module rpn_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [2:0]                    opcode_i,
  input  wire logic [rpn_pkg::EXT_WIDTH-1:0] operand_i,
  input  wire rpn_pkg::dp_cmd_t              cmd_i,
  output rpn_pkg::dp_stat_t                  stat_o,
  output logic [2:0]                         status_o,
  output logic                               value_valid_o,
  output logic [rpn_pkg::EXT_WIDTH-1:0]      popped_value_o,
  output logic [rpn_pkg::DEPTH_OUT_W-1:0]    stack_depth_o
);
  import rpn_pkg::*;

  data_t   mem_q [STACK_DEPTH];
  ptr_t    sp_q, sp_d;
  opcode_e opcode_q;
  data_t   operand_q;
  data_t   rd_a_q, rd_b_q;    // second entry and top entry
  data_t   product_q;
  data_t   result;
  data_t   quo, rem;
  logic    div_done;

  status_e                  out_status_q;
  logic                     out_vv_q;
  logic [EXT_WIDTH-1:0]     out_pop_q;
  logic [DEPTH_OUT_W-1:0]   out_depth_q;

  rpn_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (rd_a_q),
    .divisor_i   (rd_b_q),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_comb begin
    case (cmd_i.res_sel)
      RES_ADD: result = rd_a_q + rd_b_q;
      RES_SUB: result = rd_a_q - rd_b_q;
      RES_MUL: result = product_q;
      RES_QUO: result = quo;
      RES_REM: result = rem;
      default: result = rd_a_q + rd_b_q;
    endcase
  end

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.push) begin
      sp_d = sp_q + 1'b1;
    end else if (cmd_i.wr_result || cmd_i.pop) begin
      sp_d = sp_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  // Stack memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[ADDR_W'(sp_q)] <= operand_q;
    end else if (cmd_i.wr_result) begin
      mem_q[ADDR_W'(sp_q - PTR_W'(2))] <= result;
    end
    if (cmd_i.capture) begin
      rd_a_q <= mem_q[ADDR_W'(sp_q - PTR_W'(2))];
      rd_b_q <= mem_q[ADDR_W'(sp_q - PTR_W'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q  <= opcode_e'(opcode_i);
      operand_q <= from_ext(operand_i);
    end
    if (cmd_i.mul_load) begin
      product_q <= DATA_WIDTH'(rd_a_q * rd_b_q);
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_vv_q     <= cmd_i.pop;
      out_pop_q    <= cmd_i.pop ? to_ext(rd_b_q) : '0;
      out_depth_q  <= DEPTH_OUT_W'(sp_d);
    end
  end

  assign stat_o.opcode    = opcode_q;
  assign stat_o.empty     = (sp_q == '0);
  assign stat_o.below_two = (sp_q < PTR_W'(2));
  assign stat_o.full      = (sp_q >= PTR_W'(STACK_DEPTH));
  assign stat_o.top_zero  = (rd_b_q == '0);
  assign stat_o.div_done  = div_done;

  assign status_o       = out_status_q;
  assign value_valid_o  = out_vv_q;
  assign popped_value_o = out_pop_q;
  assign stack_depth_o  = out_depth_q;

endmodule : rpn_dpath
`default_nettype wire

// ===== hdl/rpn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN controller
// Token sequencer: takes a token, runs the operation through the datapath
// and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire rpn_pkg::dp_stat_t stat_i,
  output rpn_pkg::dp_cmd_t   cmd_o
);
  import rpn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIVIDE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;
  logic   in_take;

  assign slot_free  = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i & (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_sel    = RES_ADD;
    cmd_o.out_status = ST_OK;
    state_d          = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((stat_i.opcode inside {OP_DIV, OP_MOD}) && !stat_i.below_two &&
            !stat_i.top_zero) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVIDE;
        end else begin
          cmd_o.mul_load = (stat_i.opcode == OP_MUL);
          state_d        = S_FINISH;
        end
      end
      S_DIVIDE: begin
        if (stat_i.div_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
          unique case (stat_i.opcode) inside
            OP_PUSH: begin
              if (stat_i.full) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (stat_i.below_two) begin
                cmd_o.out_status = ST_MISSING;
              end else if ((stat_i.opcode == OP_DIV || stat_i.opcode == OP_MOD) &&
                           stat_i.top_zero) begin
                cmd_o.out_status = ST_DIVZERO;
              end else begin
                cmd_o.wr_result = 1'b1;
                unique case (stat_i.opcode)
                  OP_SUB:  cmd_o.res_sel = RES_SUB;
                  OP_MUL:  cmd_o.res_sel = RES_MUL;
                  OP_DIV:  cmd_o.res_sel = RES_QUO;
                  OP_MOD:  cmd_o.res_sel = RES_REM;
                  default: cmd_o.res_sel = RES_ADD;
                endcase
              end
            end
            OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.out_status = ST_MISSING;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            default: cmd_o.out_status = ST_INVALID;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : rpn_ctrl
`default_nettype wire

// ===== tb/rpn_stack_evaluator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack evaluator core testbench
// Streams push, operator and pop-result tokens through the evaluator under
// random idling on both channels. A behavioural copy of the operand stack
// predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core_tb;
  import rpn_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_TOKENS = 225;

  // One token as it is queued for the driver.
  typedef struct {
    opcode_e     op;
    logic [31:0] operand;
  } token_t;

  // One result as the block should report it.
  typedef struct {
    status_e     status;
    logic        value_valid;
    logic [31:0] popped;
    logic [4:0]  depth;
  } eval_result_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_stall_o;
  logic [2:0]                        opcode_i       = '0;
  logic signed [EXT_WIDTH-1:0]       operand_i      = '0;
  logic                              out_valid_o;
  logic                              out_stall_i    = 1'b0;
  logic [2:0]                        status_o;
  logic                              value_valid_o;
  logic signed [EXT_WIDTH-1:0]       popped_value_o;
  logic [DEPTH_OUT_W-1:0]            stack_depth_o;

  rpn_stack_evaluator_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .operand_i      (operand_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .value_valid_o  (value_valid_o),
    .popped_value_o (popped_value_o),
    .stack_depth_o  (stack_depth_o)
  );

  // Tokens waiting to be driven, and results owed by the block in order.
  token_t       pending_tokens[$];
  eval_result_t expected_results[$];

  // Behavioural copy of the operand stack, advanced on every input transfer.
  data_t        calc_stack [STACK_DEPTH];
  int           calc_depth = 0;

  // Idling rates in percent; changed between phases of the run.
  int           send_idle_pct = 38;
  int           recv_idle_pct = 66;

  // Rough entry count seen by the stimulus generator. It only steers the
  // choice of tokens, so it ignores the divide-by-zero case.
  int           shadow_depth = 0;
  int           fill_left    = 0;

  int           error_count  = 0;
  int           cycle_count  = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Evaluates one token against the stack copy and returns what the block
  // must report. Operators take the second entry as the left operand and
  // the top entry as the right one. Division is carried out on magnitudes so
  // that the most negative value divided by minus one wraps cleanly.
  function automatic eval_result_t evaluate_token(opcode_e op, logic [31:0] operand);
    eval_result_t res;
    data_t        lhs;
    data_t        rhs;
    data_t        val;
    data_t        mag_l;
    data_t        mag_r;
    res.status      = ST_OK;
    res.value_valid = 1'b0;
    res.popped      = '0;
    case (op)
      OP_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          calc_stack[calc_depth] = operand;
          calc_depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (calc_depth < 2) begin
          res.status = ST_MISSING;
        end else begin
          lhs   = calc_stack[calc_depth-2];
          rhs   = calc_stack[calc_depth-1];
          mag_l = lhs[DATA_WIDTH-1] ? ~lhs + 1'b1 : lhs;
          mag_r = rhs[DATA_WIDTH-1] ? ~rhs + 1'b1 : rhs;
          val   = '0;
          case (op)
            OP_ADD: val = lhs + rhs;
            OP_SUB: val = lhs - rhs;
            OP_MUL: val = lhs * rhs;
            OP_DIV: begin
              if (rhs != '0) begin
                val = mag_l / mag_r;
                if (lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1]) val = ~val + 1'b1;
              end
            end
            default: begin
              // The remainder follows the sign of the dividend.
              if (rhs != '0) begin
                val = mag_l % mag_r;
                if (lhs[DATA_WIDTH-1]) val = ~val + 1'b1;
              end
            end
          endcase
          if ((op == OP_DIV || op == OP_MOD) && rhs == '0) begin
            res.status = ST_DIVZERO;
          end else begin
            calc_stack[calc_depth-2] = val;
            calc_depth--;
          end
        end
      end
      OP_POP: begin
        if (calc_depth == 0) begin
          res.status = ST_MISSING;
        end else begin
          calc_depth--;
          res.popped      = calc_stack[calc_depth];
          res.value_valid = 1'b1;
        end
      end
      default: res.status = ST_INVALID;
    endcase
    res.depth = 5'(calc_depth);
    return res;
  endfunction

  // Operand values lean towards zero, small numbers and the extremes, so
  // that division by zero and signed corner cases come up often.
  function automatic logic [31:0] pick_operand();
    int kind;
    int small_val;
    kind      = $urandom_range(99);
    small_val = int'($urandom_range(16)) - 8;
    if (kind < 10) return '0;
    if (kind < 40) return 32'(small_val);
    if (kind < 52) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  task automatic queue_token(opcode_e op, logic [31:0] operand);
    token_t tok;
    tok.op      = op;
    tok.operand = operand;
    pending_tokens.push_back(tok);
    case (op)
      OP_PUSH: if (shadow_depth < STACK_DEPTH) shadow_depth++;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: if (shadow_depth >= 2) shadow_depth--;
      OP_POP: if (shadow_depth > 0) shadow_depth--;
      default: ;
    endcase
  endtask

  // Mostly well-formed expressions with random content. Now and then a run
  // of pushes drives the stack into the full condition; a few tokens are
  // invalid codes or operators on a short stack.
  task automatic queue_random_tokens(int count);
    int      pick;
    opcode_e op;
    repeat (count) begin
      pick = $urandom_range(99);
      op   = opcode_e'($urandom_range(OP_ADD, OP_MOD));
      if (fill_left > 0) begin
        fill_left--;
        op = OP_PUSH;
      end else if (pick < 3) begin
        op = OP_BAD;
      end else if (pick < 6) begin
        fill_left = $urandom_range(20, 16);
        op        = OP_PUSH;
      end else if (shadow_depth < 2) begin
        if (pick < 85) op = OP_PUSH;
        else if (pick < 93) op = OP_POP;
      end else if (shadow_depth >= STACK_DEPTH - 2) begin
        if (pick < 25) op = OP_PUSH;
        else if (pick < 40) op = OP_POP;
      end else begin
        if (pick < 50) op = OP_PUSH;
        else if (pick < 60) op = OP_POP;
      end
      queue_token(op, pick_operand());
    end
  endtask

  task automatic wait_drained();
    while (pending_tokens.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Driver: on each input transfer the token is evaluated and its result is
  // queued. A stalled token is held; otherwise the next one is offered unless
  // the sender decides to idle this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    token_t tok;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i   <= '0;
      operand_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(evaluate_token(opcode_e'(opcode_i), operand_i));
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_tokens.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tok = pending_tokens.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= tok.op;
          operand_i  <= tok.operand;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every output transfer is matched against the oldest expected
  // result. The receiver stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    eval_result_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected: status %0d value %h depth %0d",
                   $time, status_o, popped_value_o, stack_depth_o);
        end else begin
          exp_res = expected_results.pop_front();
          if (status_o !== exp_res.status) begin
            error_count++;
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status_o);
          end
          if (value_valid_o !== exp_res.value_valid) begin
            error_count++;
            $display("%0t: value_valid expected %0d actual %0d",
                     $time, exp_res.value_valid, value_valid_o);
          end
          if (popped_value_o !== exp_res.popped) begin
            error_count++;
            $display("%0t: popped_value expected %h actual %h",
                     $time, exp_res.popped, popped_value_o);
          end
          if (stack_depth_o !== exp_res.depth) begin
            error_count++;
            $display("%0t: stack_depth expected %0d actual %0d",
                     $time, exp_res.depth, stack_depth_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Underflow on an empty and a one-entry stack, an add of the two extreme
    // values, both division errors, an invalid code and a pop.
    queue_token(OP_POP,  32'h0);
    queue_token(OP_ADD,  32'h0);
    queue_token(OP_PUSH, 32'h7fff_ffff);
    queue_token(OP_SUB,  32'hffff_ffff);
    queue_token(OP_PUSH, 32'h8000_0000);
    queue_token(OP_ADD,  32'h0);
    queue_token(OP_PUSH, 32'h0);
    queue_token(OP_DIV,  32'h0);
    queue_token(OP_MOD,  32'h0);
    queue_token(OP_BAD,  32'hffff_ffff);
    queue_token(OP_POP,  32'h0);
    // Most negative value by minus one, for quotient and remainder.
    queue_token(OP_PUSH, 32'h8000_0000);
    queue_token(OP_PUSH, 32'hffff_ffff);
    queue_token(OP_DIV,  32'h0);
    queue_token(OP_PUSH, 32'hffff_ffff);
    queue_token(OP_MOD,  32'h0);
    // Truncation towards zero with a negative dividend.
    queue_token(OP_PUSH, -32'sd7);
    queue_token(OP_PUSH, 32'd2);
    queue_token(OP_DIV,  32'h0);
    queue_token(OP_PUSH, 32'd2);
    queue_token(OP_MOD,  32'h0);
    queue_token(OP_PUSH, 32'h7fff_ffff);
    queue_token(OP_MUL,  32'h0);
    queue_token(OP_POP,  32'h0);
    queue_token(OP_POP,  32'h0);
    queue_token(OP_POP,  32'h0);

    // Open the random part with a fill so that a full stack is met early.
    fill_left = STACK_DEPTH + 2;
    queue_random_tokens(RANDOM_TOKENS);
    wait_drained();

    send_idle_pct = 66;
    recv_idle_pct = 38;
    queue_random_tokens(RANDOM_TOKENS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_tokens(RANDOM_TOKENS);
    wait_drained();

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : rpn_stack_evaluator_core_tb
